>>> src/infix_to_postfix_converter_defines.svh
// Assertion macros used by the checker.
// No dependencies.
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define I2P_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2p check failed");

// Next-cycle implication, disabled while reset is held.
`define I2P_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2p check failed");

`endif

>>> src/i2p_pkg.sv
// Types, codes and sizes for the infix to postfix converter.
// No dependencies; used by every module of the block.
package i2p_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  typedef enum logic [3:0] {
    CMD_OPERAND = 4'd0,
    CMD_OPEN    = 4'd1,
    CMD_CLOSE   = 4'd2,
    CMD_PLUS    = 4'd3,
    CMD_MINUS   = 4'd4,
    CMD_TIMES   = 4'd5,
    CMD_DIVIDE  = 4'd6,
    CMD_POWER   = 4'd7,
    CMD_END     = 4'd8
  } cmd_t;

  // Output token kinds; stack entries use the same codes, with zero for an open.
  typedef enum logic [2:0] {
    KIND_OPERAND = 3'd0,
    KIND_PLUS    = 3'd1,
    KIND_MINUS   = 3'd2,
    KIND_TIMES   = 3'd3,
    KIND_DIVIDE  = 3'd4,
    KIND_POWER   = 3'd5,
    KIND_END     = 3'd6
  } kind_t;

  localparam logic [2:0] STK_OPEN = 3'd0;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_CLOSE    = 2'd1,
    STAT_OVERFLOW = 2'd2,
    STAT_OPEN_END = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_RUN,
    FSM_FLUSH
  } fsm_t;

  typedef struct packed {
    logic [2:0]             kind;
    logic [VALUE_WIDTH-1:0] value;
    logic [1:0]             status;
  } res_t;

  typedef struct packed {
    logic load;
    logic step;
    logic flush;
  } i2p_cmd_t;

  typedef struct packed {
    logic cmd_known;
    logic out_space;
    logic step_gen;
    logic step_fin;
    logic pend_v;
  } i2p_stat_t;

endpackage

>>> src/i2p_ctrl.sv
// Sequencer for the converter: accept, step the stack, flush the held word.
// Depends on i2p_pkg.
module i2p_ctrl import i2p_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  i2p_stat_t stat,
  output i2p_cmd_t  cmd
);

  fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: begin
        if (in_tvalid && stat.cmd_known) state_nxt = FSM_RUN;
      end
      FSM_RUN: begin
        if (stat.out_space && stat.step_fin) begin
          if (stat.step_gen && stat.pend_v) state_nxt = FSM_FLUSH;
          else state_nxt = FSM_IDLE;
        end
      end
      FSM_FLUSH: begin
        if (stat.out_space) state_nxt = FSM_IDLE;
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      FSM_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid && stat.cmd_known;
      end
      FSM_RUN:   cmd.step  = stat.out_space;
      FSM_FLUSH: cmd.flush = stat.out_space;
      default: ;
    endcase
  end

endmodule

>>> src/i2p_dpath.sv
// Operator stack, token decode, held word and output register.
// Depends on i2p_pkg.
module i2p_dpath import i2p_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [31:0]            in_tdata,
  input  logic [3:0]             in_tuser,
  input  i2p_cmd_t               cmd,
  output i2p_stat_t              stat,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [VALUE_WIDTH-1:0] out_tdata,
  output logic                   out_tlast,
  output logic [4:0]             out_tuser
);

  logic [2:0]       stack_r [STACK_DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;
  cmd_t             cmd_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic             open_left_r, open_left_nxt;
  logic             pend_v_r, pend_v_nxt;
  res_t             pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_r, out_nxt;
  logic             out_last_r, out_last_nxt;

  logic             has_top, full;
  logic [IDX_W-1:0] top_idx;
  logic [2:0]       top;
  logic             do_pop, do_push, do_drop, gen, fin, set_open;
  logic [2:0]       push_code;
  res_t             gen_res;
  logic             out_space;

  assign has_top   = (count_r != '0);
  assign full      = (count_r == CNT_W'(STACK_DEPTH));
  assign top_idx   = IDX_W'(count_r - CNT_W'(1));
  assign top       = stack_r[top_idx];
  assign out_space = !out_valid_r || out_tready;

  always_comb begin
    do_pop    = 1'b0;
    do_push   = 1'b0;
    do_drop   = 1'b0;
    gen       = 1'b0;
    fin       = 1'b0;
    set_open  = 1'b0;
    push_code = STK_OPEN;
    gen_res   = '{kind: KIND_OPERAND, value: '0, status: STAT_OK};
    case (cmd_r)
      CMD_OPERAND: begin
        gen           = 1'b1;
        fin           = 1'b1;
        gen_res.value = val_r;
      end
      CMD_OPEN: begin
        push_code = STK_OPEN;
        do_push   = 1'b1;
      end
      CMD_CLOSE: begin
        if (has_top && top != STK_OPEN) begin
          do_pop = 1'b1;
        end else if (has_top) begin
          do_drop = 1'b1;
          fin     = 1'b1;
        end else begin
          gen            = 1'b1;
          fin            = 1'b1;
          gen_res.status = STAT_CLOSE;
        end
      end
      CMD_PLUS, CMD_MINUS: begin
        push_code = (cmd_r == CMD_PLUS) ? KIND_PLUS : KIND_MINUS;
        if (has_top && top != STK_OPEN) do_pop = 1'b1;
        else do_push = 1'b1;
      end
      CMD_TIMES, CMD_DIVIDE: begin
        push_code = (cmd_r == CMD_TIMES) ? KIND_TIMES : KIND_DIVIDE;
        if (has_top && top >= KIND_TIMES) do_pop = 1'b1;
        else do_push = 1'b1;
      end
      CMD_POWER: begin
        push_code = KIND_POWER;
        if (has_top && top == KIND_POWER) do_pop = 1'b1;
        else do_push = 1'b1;
      end
      CMD_END: begin
        if (has_top && top == STK_OPEN) begin
          do_drop  = 1'b1;
          set_open = 1'b1;
        end else if (has_top) begin
          do_pop = 1'b1;
        end else begin
          gen            = 1'b1;
          fin            = 1'b1;
          gen_res.kind   = KIND_END;
          gen_res.status = open_left_r ? STAT_OPEN_END : STAT_OK;
        end
      end
      default: fin = 1'b1;
    endcase
    if (do_pop) begin
      gen          = 1'b1;
      gen_res.kind = top;
    end
    if (do_push) begin
      fin = 1'b1;
      if (full) begin
        do_push        = 1'b0;
        gen            = 1'b1;
        gen_res.status = STAT_OVERFLOW;
      end
    end
  end

  // stack count and bookkeeping
  always_comb begin
    count_nxt     = count_r;
    open_left_nxt = open_left_r;
    if (cmd.load) begin
      open_left_nxt = 1'b0;
    end else if (cmd.step) begin
      if (do_pop || do_drop) count_nxt = count_r - CNT_W'(1);
      else if (do_push) count_nxt = count_r + CNT_W'(1);
      if (set_open) open_left_nxt = 1'b1;
    end
  end

  // held word and output register: a result is sent only once the next is known
  always_comb begin
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_nxt       = out_r;
    out_last_nxt  = out_last_r;
    if (cmd.step) begin
      if (gen) begin
        if (pend_v_r) begin
          out_valid_nxt = 1'b1;
          out_nxt       = pend_r;
          out_last_nxt  = 1'b0;
          pend_nxt      = gen_res;
        end else if (fin) begin
          out_valid_nxt = 1'b1;
          out_nxt       = gen_res;
          out_last_nxt  = 1'b1;
        end else begin
          pend_v_nxt = 1'b1;
          pend_nxt   = gen_res;
        end
      end else if (fin && pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = pend_r;
        out_last_nxt  = 1'b1;
        pend_v_nxt    = 1'b0;
      end
    end else if (cmd.flush) begin
      out_valid_nxt = 1'b1;
      out_nxt       = pend_r;
      out_last_nxt  = 1'b1;
      pend_v_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      open_left_r <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      open_left_r <= open_left_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
    if (cmd.load) begin
      cmd_r <= cmd_t'(in_tuser);
      val_r <= in_tdata[VALUE_WIDTH-1:0];
    end
    if (cmd.step && do_push) stack_r[count_r[IDX_W-1:0]] <= push_code;
  end

  assign stat.cmd_known = (in_tuser <= CMD_END);
  assign stat.out_space = out_space;
  assign stat.step_gen  = gen;
  assign stat.step_fin  = fin;
  assign stat.pend_v    = pend_v_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.value;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_r.status, out_r.kind};

endmodule

>>> src/infix_to_postfix_converter.sv
// Top level of the shunting-yard infix to postfix converter.
// Depends on i2p_pkg, i2p_ctrl and i2p_dpath.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata value, tuser command
//  out_    | out | out_tvalid/tready  | tdata value, tuser kind/status, tlast
//
// A token that pops nothing is accepted, then decoded.
// Each popped operator, and each open dropped at end, adds a decode step; a
// flush step follows when a token both pops and ends in an error or end word.
// rst_n is synchronous; it empties the stack and drops any word in flight.
// A stalled output holds the decode loop; no new token is taken until done.
module infix_to_postfix_converter import i2p_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [31:0]            in_tdata,   // [31:0] operand_value
  input  logic [3:0]             in_tuser,   // [3:0] command
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [VALUE_WIDTH-1:0] out_tdata,  // [31:0] token_value
  output logic                   out_tlast,
  output logic [4:0]             out_tuser   // [2:0] token_kind, [4:3] status
);

  i2p_cmd_t  cmd;
  i2p_stat_t stat;

  i2p_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  i2p_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

>>> src/i2p_checker.sv
// Port-level checks for the converter, bound to the top level.
// Depends on i2p_pkg and infix_to_postfix_converter_defines.svh.
`include "infix_to_postfix_converter_defines.svh"

module i2p_checker import i2p_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [VALUE_WIDTH-1:0] out_tdata,
  input logic                   out_tlast,
  input logic [4:0]             out_tuser
);

  logic [VALUE_WIDTH+5:0] out_word;
  logic [2:0]             out_kind;
  logic [1:0]             out_status;
  logic                   err_word;

  assign out_word   = {out_tdata, out_tuser, out_tlast};
  assign out_kind   = out_tuser[2:0];
  assign out_status = out_tuser[4:3];
  assign err_word   = (out_status == STAT_CLOSE) || (out_status == STAT_OVERFLOW);

  `I2P_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_word))
  `I2P_ASSERT_NOW(a_end_last, clk, rst_n, out_tvalid && out_kind == KIND_END, out_tlast)
  `I2P_ASSERT_NOW(a_err_last, clk, rst_n, out_tvalid && err_word, out_tlast && out_kind == KIND_OPERAND)
  `I2P_ASSERT_NOW(a_op_zero, clk, rst_n, out_tvalid && out_kind != KIND_OPERAND, out_tdata == '0)

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
